// ===== design/bsm_pkg.sv =====
`default_nettype none

package bsm_pkg;

    // Default coordinate width: signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;

    // Operation codes on the mode input
    localparam logic MODE_MERGE   = 1'b0;
    localparam logic MODE_OVERLAP = 1'b1;

endpackage

`default_nettype wire

// ===== design/bounding_sphere_merge_and_overlap_unit.sv =====
// Bounding sphere merge and overlap unit.
// Input channel (in_valid / in_ready) carries one pair of spheres and a mode
// per transfer: mode MERGE returns the smallest sphere enclosing both, mode
// OVERLAP flags whether the centre distance is strictly below the radius sum.
// Output channel (out_valid / out_ready) carries exactly one result per input
// transfer, in order.
// Throughput: one pair per cycle, sustained while the receiver does not stall.
// The pipeline is built from the square-root pipeline (one root bit per stage,
// COORD_WIDTH + 1 stages) and the three-lane divider pipeline (one quotient
// bit per stage, COORD_WIDTH + 1 stages), around difference, magnitude,
// squaring, sum, decision, product and output stages.
// Reset (rst_n low, asynchronous) empties the pipeline: every stage valid
// bit clears and out_valid drops; payload registers are not reset.
// When the receiver stalls (out_valid high, out_ready low) the whole pipeline
// holds and in_ready drops; no item is lost or repeated. Bubbles in the
// pipeline are never squeezed out, since all stages advance together; in_ready
// stays high while the output register is empty or being drained.
`default_nettype none

module bounding_sphere_merge_and_overlap_unit #(
    parameter int COORD_WIDTH = bsm_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic signed [COORD_WIDTH-1:0] first_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_y,
    input  wire logic signed [COORD_WIDTH-1:0] first_z,
    input  wire logic        [COORD_WIDTH-2:0] first_radius,
    input  wire logic signed [COORD_WIDTH-1:0] second_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_z,
    input  wire logic        [COORD_WIDTH-2:0] second_radius,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed      [COORD_WIDTH-1:0] merged_x,
    output logic signed      [COORD_WIDTH-1:0] merged_y,
    output logic signed      [COORD_WIDTH-1:0] merged_z,
    output logic             [COORD_WIDTH-2:0] merged_radius,
    output logic                               overlaps,
    output logic                               saturated
);

    // Widths
    localparam int CW = COORD_WIDTH;     // centre coordinate
    localparam int RW = CW - 1;          // radius
    localparam int UW = CW + 1;          // signed difference / its magnitude
    localparam int DW = CW + 1;          // distance (root)
    localparam int SW = 2 * CW + 2;      // squared distance
    localparam int TW = CW + 2;          // distance sums, divisor
    localparam int NW = 2 * CW + 3;      // dividend |d| * t
    localparam int QW = CW + 1;          // quotient

    // Stage map
    localparam int ST_DIFF = 0;
    localparam int ST_ABS  = 1;
    localparam int ST_SQR  = 2;
    localparam int ST_SUM  = 3;
    localparam int SQ0     = 4;
    localparam int ST_DEC  = SQ0 + DW;
    localparam int ST_MUL  = ST_DEC + 1;
    localparam int DV0     = ST_MUL + 1;
    localparam int ST_OUT  = DV0 + QW;
    localparam int NST     = ST_OUT + 1;

    typedef struct packed {
        logic                  mode;
        logic [2:0][CW-1:0]    a;      // first centre, later result centre
        logic [2:0][UW-1:0]    d;      // second - first, later its magnitude
        logic [2:0]            neg;
        logic [RW-1:0]         ra;
        logic [RW-1:0]         rb;
        logic [CW-1:0]         rs;
        logic [2:0][SW-1:0]    sq;
        logic [SW-1:0]         rs2;
        logic [SW-1:0]         srem;
        logic [DW-1:0]         root;
        logic                  ov;
        logic                  c1;
        logic                  c2;
        logic [TW-1:0]         t;
        logic [TW-1:0]         den;
        logic [RW-1:0]         rad;
        logic                  rsat;   // radius clamp, later any clamp
        logic [2:0][NW-1:0]    num;
        logic [2:0][QW-1:0]    q;
    } pl_t;

    pl_t            pipe_reg  [NST];
    pl_t            pipe_next [NST];
    logic [NST-1:0] vld_reg;
    logic           en;

    // Whole pipeline advances unless the output holds an untaken result
    assign en       = !vld_reg[ST_OUT] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // Difference of centres, radius sum
    always_comb
    begin
        pipe_next[ST_DIFF]      = '0;
        pipe_next[ST_DIFF].mode = mode;
        pipe_next[ST_DIFF].a[0] = first_x;
        pipe_next[ST_DIFF].a[1] = first_y;
        pipe_next[ST_DIFF].a[2] = first_z;
        pipe_next[ST_DIFF].d[0] = {second_x[CW-1], second_x} - {first_x[CW-1], first_x};
        pipe_next[ST_DIFF].d[1] = {second_y[CW-1], second_y} - {first_y[CW-1], first_y};
        pipe_next[ST_DIFF].d[2] = {second_z[CW-1], second_z} - {first_z[CW-1], first_z};
        pipe_next[ST_DIFF].ra   = first_radius;
        pipe_next[ST_DIFF].rb   = second_radius;
        pipe_next[ST_DIFF].rs   = {1'b0, first_radius} + {1'b0, second_radius};
    end

    // Magnitudes and signs of the difference
    always_comb
    begin
        pipe_next[ST_ABS] = pipe_reg[ST_ABS-1];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_ABS].neg[i] = pipe_reg[ST_ABS-1].d[i][UW-1];
            if (pipe_reg[ST_ABS-1].d[i][UW-1])
            begin
                pipe_next[ST_ABS].d[i] = -pipe_reg[ST_ABS-1].d[i];
            end
        end
    end

    // Squares
    always_comb
    begin
        pipe_next[ST_SQR] = pipe_reg[ST_SQR-1];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_SQR].sq[i] = SW'(pipe_reg[ST_SQR-1].d[i])
                                    * SW'(pipe_reg[ST_SQR-1].d[i]);
        end
        pipe_next[ST_SQR].rs2 = SW'(pipe_reg[ST_SQR-1].rs) * SW'(pipe_reg[ST_SQR-1].rs);
    end

    // Squared distance and overlap test
    always_comb
    begin
        pipe_next[ST_SUM]      = pipe_reg[ST_SUM-1];
        pipe_next[ST_SUM].srem = pipe_reg[ST_SUM-1].sq[0] + pipe_reg[ST_SUM-1].sq[1]
                               + pipe_reg[ST_SUM-1].sq[2];
        pipe_next[ST_SUM].ov   = pipe_next[ST_SUM].srem < pipe_reg[ST_SUM-1].rs2;
        pipe_next[ST_SUM].root = '0;
    end

    // Integer square root, one root bit per stage, most significant first
    for (genvar k = SQ0; k < ST_DEC; k++)
    begin : g_sqrt
        localparam int BI = DW - 1 - (k - SQ0);
        logic [SW:0] trial;

        always_comb
        begin
            trial        = ((SW+1)'(pipe_reg[k-1].root) << (BI + 1))
                         + ((SW+1)'(1) << (2 * BI));
            pipe_next[k] = pipe_reg[k-1];
            if ({1'b0, pipe_reg[k-1].srem} >= trial)
            begin
                pipe_next[k].srem     = SW'({1'b0, pipe_reg[k-1].srem} - trial);
                pipe_next[k].root[BI] = 1'b1;
            end
        end
    end

    // Containment tests, radius, divisor
    logic [TW-1:0] dec_dist;
    logic [TW-1:0] dec_rsum;
    logic [TW-2:0] dec_half;

    always_comb
    begin
        dec_dist           = TW'(pipe_reg[ST_DEC-1].root);
        dec_rsum           = dec_dist + TW'(pipe_reg[ST_DEC-1].ra) + TW'(pipe_reg[ST_DEC-1].rb);
        dec_half           = dec_rsum[TW-1:1];
        pipe_next[ST_DEC]  = pipe_reg[ST_DEC-1];
        pipe_next[ST_DEC].c1 = (dec_dist + TW'(pipe_reg[ST_DEC-1].rb))
                             <= TW'(pipe_reg[ST_DEC-1].ra);
        pipe_next[ST_DEC].c2 = (dec_dist + TW'(pipe_reg[ST_DEC-1].ra))
                             <= TW'(pipe_reg[ST_DEC-1].rb);
        pipe_next[ST_DEC].t  = dec_dist + TW'(pipe_reg[ST_DEC-1].rb)
                             - TW'(pipe_reg[ST_DEC-1].ra);
        pipe_next[ST_DEC].den  = {dec_dist[TW-2:0], 1'b0};
        pipe_next[ST_DEC].rsat = dec_half[TW-2:RW] != '0;
        pipe_next[ST_DEC].rad  = pipe_next[ST_DEC].rsat ? {RW{1'b1}} : dec_half[RW-1:0];
    end

    // Dividends |d| * t
    always_comb
    begin
        pipe_next[ST_MUL] = pipe_reg[ST_MUL-1];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_MUL].num[i] = NW'(pipe_reg[ST_MUL-1].d[i]) * NW'(pipe_reg[ST_MUL-1].t);
            pipe_next[ST_MUL].q[i]   = '0;
        end
    end

    // Restoring division in three lanes, one quotient bit per stage
    for (genvar k = DV0; k < ST_OUT; k++)
    begin : g_div
        localparam int BJ = QW - 1 - (k - DV0);
        logic [NW-1:0] dsh;

        always_comb
        begin
            dsh          = NW'(pipe_reg[k-1].den) << BJ;
            pipe_next[k] = pipe_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                if (pipe_reg[k-1].num[i] >= dsh)
                begin
                    pipe_next[k].num[i]  = pipe_reg[k-1].num[i] - dsh;
                    pipe_next[k].q[i][BJ] = 1'b1;
                end
            end
        end
    end

    // Apply sign, clamp, select the merge case; zero the sphere in overlap mode
    logic [2:0][QW-1:0] out_mag;
    logic [2:0][CW+1:0] out_sum;
    logic [2:0][CW+1:0] out_off;
    logic [2:0]         out_clamp;
    logic               out_gen;

    always_comb
    begin
        pipe_next[ST_OUT] = pipe_reg[ST_OUT-1];
        out_gen = !pipe_reg[ST_OUT-1].c1 && !pipe_reg[ST_OUT-1].c2;
        for (int i = 0; i < 3; i++)
        begin
            if (pipe_reg[ST_OUT-1].c1)
            begin
                out_mag[i] = '0;
            end
            else if (pipe_reg[ST_OUT-1].c2)
            begin
                out_mag[i] = pipe_reg[ST_OUT-1].d[i];
            end
            else
            begin
                out_mag[i] = pipe_reg[ST_OUT-1].q[i];
            end
            out_off[i] = pipe_reg[ST_OUT-1].neg[i] ? -{1'b0, out_mag[i]} : {1'b0, out_mag[i]};
            out_sum[i] = {{2{pipe_reg[ST_OUT-1].a[i][CW-1]}}, pipe_reg[ST_OUT-1].a[i]}
                       + out_off[i];
            out_clamp[i] = (out_sum[i][CW+1:CW-1] != '0)
                        && (out_sum[i][CW+1:CW-1] != '1);
            if (pipe_reg[ST_OUT-1].mode == bsm_pkg::MODE_OVERLAP)
            begin
                pipe_next[ST_OUT].a[i] = '0;
            end
            else if (out_clamp[i])
            begin
                pipe_next[ST_OUT].a[i] = out_sum[i][CW+1] ? {1'b1, {(CW-1){1'b0}}}
                                                           : {1'b0, {(CW-1){1'b1}}};
            end
            else
            begin
                pipe_next[ST_OUT].a[i] = out_sum[i][CW-1:0];
            end
        end
        if (pipe_reg[ST_OUT-1].mode == bsm_pkg::MODE_OVERLAP)
        begin
            pipe_next[ST_OUT].rad  = '0;
            pipe_next[ST_OUT].rsat = 1'b0;
        end
        else if (pipe_reg[ST_OUT-1].c1)
        begin
            pipe_next[ST_OUT].rad  = pipe_reg[ST_OUT-1].ra;
            pipe_next[ST_OUT].rsat = 1'b0;
        end
        else if (pipe_reg[ST_OUT-1].c2)
        begin
            pipe_next[ST_OUT].rad  = pipe_reg[ST_OUT-1].rb;
            pipe_next[ST_OUT].rsat = 1'b0;
        end
        else
        begin
            pipe_next[ST_OUT].rsat = out_gen && (pipe_reg[ST_OUT-1].rsat || (out_clamp != '0));
        end
    end

    assign out_valid     = vld_reg[ST_OUT];
    assign merged_x      = pipe_reg[ST_OUT].a[0];
    assign merged_y      = pipe_reg[ST_OUT].a[1];
    assign merged_z      = pipe_reg[ST_OUT].a[2];
    assign merged_radius = pipe_reg[ST_OUT].rad;
    assign overlaps      = pipe_reg[ST_OUT].ov;
    assign saturated     = pipe_reg[ST_OUT].rsat;

    // Root remainder never exceeds twice the root
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DEC-1] |-> (pipe_reg[ST_DEC-1].srem <= {pipe_reg[ST_DEC-1].root, 1'b0}))
        else $error("square root remainder out of range");

    // In the general merge case the division remainder ends below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_OUT-1] && !pipe_reg[ST_OUT-1].mode && !pipe_reg[ST_OUT-1].c1
         && !pipe_reg[ST_OUT-1].c2)
        |-> (pipe_reg[ST_OUT-1].num[0] < NW'(pipe_reg[ST_OUT-1].den)
          && pipe_reg[ST_OUT-1].num[1] < NW'(pipe_reg[ST_OUT-1].den)
          && pipe_reg[ST_OUT-1].num[2] < NW'(pipe_reg[ST_OUT-1].den)))
        else $error("division remainder not below divisor");

    // A stalled pipeline keeps its occupancy
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // Overlap results carry no sphere and no clamp
    a_ovl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_OUT-1] && en && pipe_reg[ST_OUT-1].mode == bsm_pkg::MODE_OVERLAP)
        |=> (merged_radius == '0 && !saturated))
        else $error("overlap result carries merge data");

endmodule

`default_nettype wire
